### hdl/leg_swing_trajectory_point_top_macros.svh
// Assertion macros used by the checker of this block.
`ifndef LEG_SWING_TRAJECTORY_POINT_TOP_MACROS_SVH
`define LEG_SWING_TRAJECTORY_POINT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSTP_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lstp check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSTP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lstp check failed");

`endif

### hdl/lstp_pkg.sv
package lstp_pkg;

  localparam int SWING_POINTS_DEF = 50;

  // Numerator width of the phase divider: step_index shifted up by 16.
  localparam int NUM_W = 22;

  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [17:0] THREE_Q16  = 18'd196608;
  localparam logic [18:0] FOUR_Q16   = 19'd262144;
  localparam logic [15:0] DEADBAND   = 16'd40;
  // floor(w / 5) == (w * DIV5_MUL) >> DIV5_SH for every w below 2^18.
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SH    = 18;
  localparam logic [34:0] HALF_5Q16  = 35'd163840;

  localparam logic [14:0]        STEP_LENGTH_RST = 15'd1024;
  localparam logic [14:0]        CLEARANCE_RST   = 15'd768;
  localparam logic signed [15:0] STAND_H_RST     = -16'sd6144;
  localparam logic [14:0]        TURN_GAIN_RST   = 15'd256;
  localparam logic [15:0]        LIFT_FRAC_RST   = 16'd19661;
  localparam logic [15:0]        XFER_FRAC_RST   = 16'd26214;
  localparam logic [15:0]        LOWER_FRAC_RST  = 16'd19661;

  typedef enum logic [2:0] {
    REG_STEP_LENGTH = 3'd0,
    REG_CLEARANCE   = 3'd1,
    REG_STAND_H     = 3'd2,
    REG_TURN_GAIN   = 3'd3,
    REG_LIFT_FRAC   = 3'd4,
    REG_XFER_FRAC   = 3'd5,
    REG_LOWER_FRAC  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_LIFT  = 2'd0,
    PH_XFER  = 2'd1,
    PH_LOWER = 2'd2
  } phase_t;

  // Per-item data that rides alongside the phase divider.
  typedef struct packed {
    phase_t             phase;
    logic [16:0]        pr;
    logic [2:0]         leg;
    logic               fwd;
    logic               neg;
    logic               side;
    logic               turn;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] vy;
    logic signed [15:0] tr;
  } tag_t;

endpackage

### hdl/lstp_div.sv
module lstp_div #(
  parameter int DEN_W = 22,
  parameter int CMP_W = 23
) (
  input  logic               clk,
  input  logic [8:0]         en,
  input  logic [CMP_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  input  lstp_pkg::tag_t     tag_in,
  output logic [16:0]        q_out,
  output lstp_pkg::tag_t     tag_out
);

  logic [DEN_W-1:0] rem_r [0:8];
  logic [DEN_W-1:0] den_r [0:8];
  logic [15:0]      q_r   [0:8];
  logic             sat_r [0:8];
  lstp_pkg::tag_t   tag_r [0:8];

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [DEN_W:0] div_step(logic [DEN_W-1:0] rem, logic [DEN_W-1:0] d);
    logic [DEN_W:0] r2;
    logic [DEN_W:0] diff;
    r2   = {rem, 1'b0};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      return {1'b1, diff[DEN_W-1:0]};
    end
    return {1'b0, r2[DEN_W-1:0]};
  endfunction

  // A ratio of one or more, or a zero divisor, saturates to 1.0.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sat_r[0] <= (den == '0) || (num >= CMP_W'(den));
      rem_r[0] <= (num >= CMP_W'(den)) ? '0 : DEN_W'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      tag_r[0] <= tag_in;
    end
  end

  for (genvar j = 1; j <= 8; j++) begin : g_stage
    logic [DEN_W:0] s1_nxt;
    logic [DEN_W:0] s2_nxt;
    assign s1_nxt = div_step(rem_r[j-1], den_r[j-1]);
    assign s2_nxt = div_step(s1_nxt[DEN_W-1:0], den_r[j-1]);
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= s2_nxt[DEN_W-1:0];
        q_r[j]   <= {q_r[j-1][13:0], s1_nxt[DEN_W], s2_nxt[DEN_W]};
        den_r[j] <= den_r[j-1];
        sat_r[j] <= sat_r[j-1];
        tag_r[j] <= tag_r[j-1];
      end
    end
  end

  assign q_out   = sat_r[8] ? lstp_pkg::ONE_Q16 : {1'b0, q_r[8]};
  assign tag_out = tag_r[8];

endmodule

### hdl/leg_swing_trajectory_point_top.sv
// Depth: 18 register stages; result words leave them in the order in which
// their input words were accepted.
// Throughput: one word per cycle; each stage holds its word under a stall and
// takes a new one whenever it is empty or its successor moves on.
// The phase ratio comes from a pipelined divider, two quotient bits per stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults. The configuration port is always ready.
module leg_swing_trajectory_point_top #(
  parameter int SWING_POINTS = lstp_pkg::SWING_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] step_index, [8:6] leg_id, [24:9] base_x, [40:25] base_y,
  // [56:41] vel_x, [72:57] vel_y, [88:73] turn_rate, [95:89] zero
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] foot_x, [31:16] foot_y, [47:32] foot_z
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int NS     = 18;
  localparam int N_W    = $clog2(SWING_POINTS + 1);
  localparam int DEN_W  = 16 + N_W;
  localparam int B_W    = DEN_W + 1;
  localparam int CMP_W  = (B_W > lstp_pkg::NUM_W) ? B_W : lstp_pkg::NUM_W;
  localparam int SN_W   = (N_W > 6) ? N_W : 6;
  localparam int TURN_K = 34;
  localparam logic [N_W-1:0] N_VAL = N_W'(SWING_POINTS);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << TURN_K) + 64'(SWING_POINTS) - 64'd1) / 64'(SWING_POINTS);
  localparam logic [TURN_K-1:0] RECIP = RECIP_FULL[TURN_K-1:0];

  // Configuration registers.
  logic [14:0]        step_len_r, clear_r, gain_r;
  logic signed [15:0] stand_r;
  logic [15:0]        lift_r, xfer_r, lower_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r <= lstp_pkg::STEP_LENGTH_RST;
      clear_r    <= lstp_pkg::CLEARANCE_RST;
      stand_r    <= lstp_pkg::STAND_H_RST;
      gain_r     <= lstp_pkg::TURN_GAIN_RST;
      lift_r     <= lstp_pkg::LIFT_FRAC_RST;
      xfer_r     <= lstp_pkg::XFER_FRAC_RST;
      lower_r    <= lstp_pkg::LOWER_FRAC_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lstp_pkg::cfg_reg_t'(cfg_addr))
        lstp_pkg::REG_STEP_LENGTH: step_len_r <= cfg_data[14:0];
        lstp_pkg::REG_CLEARANCE:   clear_r    <= cfg_data[14:0];
        lstp_pkg::REG_STAND_H:     stand_r    <= $signed(cfg_data);
        lstp_pkg::REG_TURN_GAIN:   gain_r     <= cfg_data[14:0];
        lstp_pkg::REG_LIFT_FRAC:   lift_r     <= cfg_data;
        lstp_pkg::REG_XFER_FRAC:   xfer_r     <= cfg_data;
        lstp_pkg::REG_LOWER_FRAC:  lower_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage enables.
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  // Stage A: phase boundaries and the turn phase ratio.
  logic [5:0]               in_step;
  logic signed [15:0]       in_vx;
  logic [TURN_K+5:0]        pr_prod;
  logic [16:0]              pr_nxt;
  lstp_pkg::tag_t           tag_nxt;
  logic [5:0]               step_a_r;
  logic [DEN_W-1:0]         a_a_r, dt_a_r, dl_a_r;
  logic [B_W-1:0]           b_a_r;
  lstp_pkg::tag_t           tag_a_r;

  assign in_step = in_tdata[5:0];
  assign in_vx   = $signed(in_tdata[56:41]);
  assign pr_prod = (TURN_K + 6)'(in_step) * (TURN_K + 6)'(RECIP);
  assign pr_nxt  = (SN_W'(in_step) >= SN_W'(N_VAL)) ? lstp_pkg::ONE_Q16
                 : {1'b0, pr_prod[TURN_K-1:TURN_K-16]};

  always_comb begin
    tag_nxt       = '0;
    tag_nxt.phase = lstp_pkg::PH_LIFT;
    tag_nxt.pr    = pr_nxt;
    tag_nxt.leg   = in_tdata[8:6];
    tag_nxt.bx    = $signed(in_tdata[24:9]);
    tag_nxt.by    = $signed(in_tdata[40:25]);
    tag_nxt.vy    = $signed(in_tdata[72:57]);
    tag_nxt.tr    = $signed(in_tdata[88:73]);
    tag_nxt.fwd   = (in_vx > $signed(lstp_pkg::DEADBAND))
                 || (in_vx < -$signed(lstp_pkg::DEADBAND));
    tag_nxt.neg   = !(in_vx > 16'sd0);
    tag_nxt.side  = (tag_nxt.vy > $signed(lstp_pkg::DEADBAND))
                 || (tag_nxt.vy < -$signed(lstp_pkg::DEADBAND));
    tag_nxt.turn  = (tag_nxt.tr > $signed(lstp_pkg::DEADBAND))
                 || (tag_nxt.tr < -$signed(lstp_pkg::DEADBAND));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      step_a_r <= in_step;
      a_a_r    <= DEN_W'(lift_r) * DEN_W'(N_VAL);
      b_a_r    <= (B_W'(lift_r) + B_W'(xfer_r)) * B_W'(N_VAL);
      dt_a_r   <= DEN_W'(xfer_r) * DEN_W'(N_VAL);
      dl_a_r   <= DEN_W'(lower_r) * DEN_W'(N_VAL);
      tag_a_r  <= tag_nxt;
    end
  end

  // Stage B: pick the phase and the divider operands.
  logic [CMP_W-1:0] t_b, a_b, b_b;
  logic [CMP_W-1:0] num_b_nxt;
  logic [DEN_W-1:0] den_b_nxt;
  lstp_pkg::tag_t   tag_b_nxt;
  logic [CMP_W-1:0] num_b_r;
  logic [DEN_W-1:0] den_b_r;
  lstp_pkg::tag_t   tag_b_r;

  assign t_b = CMP_W'({step_a_r, 16'b0});
  assign a_b = CMP_W'(a_a_r);
  assign b_b = CMP_W'(b_a_r);

  always_comb begin
    tag_b_nxt = tag_a_r;
    priority if (t_b <= a_b) begin
      tag_b_nxt.phase = lstp_pkg::PH_LIFT;
      num_b_nxt       = t_b;
      den_b_nxt       = a_a_r;
    end else if (t_b <= b_b) begin
      tag_b_nxt.phase = lstp_pkg::PH_XFER;
      num_b_nxt       = t_b - a_b;
      den_b_nxt       = dt_a_r;
    end else begin
      tag_b_nxt.phase = lstp_pkg::PH_LOWER;
      num_b_nxt       = t_b - b_b;
      den_b_nxt       = dl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tag_b_r <= tag_b_nxt;
      num_b_r <= num_b_nxt;
      den_b_r <= den_b_nxt;
    end
  end

  // Stages 2 to 10: phase ratio.
  logic [16:0]    div_q;
  lstp_pkg::tag_t div_tag;

  lstp_div #(
    .DEN_W (DEN_W),
    .CMP_W (CMP_W)
  ) u_div (
    .clk     (clk),
    .en      (en[10:2]),
    .num     (num_b_r),
    .den     (den_b_r),
    .tag_in  (tag_b_r),
    .q_out   (div_q),
    .tag_out (div_tag)
  );

  // Smoothstep for both ratios: square, then cubic term, then rounding.
  logic [16:0]    r1_r, p1_r;
  logic [32:0]    rr1_r, pp1_r;
  lstp_pkg::tag_t tg1_r;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      r1_r  <= div_q;
      p1_r  <= div_tag.pr;
      rr1_r <= 33'(div_q) * 33'(div_q);
      pp1_r <= 33'(div_tag.pr) * 33'(div_tag.pr);
      tg1_r <= div_tag;
    end
  end

  logic [16:0]    r2_r;
  logic [50:0]    c2_r, pc2_r;
  lstp_pkg::tag_t tg2_r;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      r2_r  <= r1_r;
      c2_r  <= 51'(rr1_r) * 51'(lstp_pkg::THREE_Q16 - {r1_r, 1'b0});
      pc2_r <= 51'(pp1_r) * 51'(lstp_pkg::THREE_Q16 - {p1_r, 1'b0});
      tg2_r <= tg1_r;
    end
  end

  logic [50:0]    c2_rnd, pc2_rnd;
  logic [16:0]    r3_r, s3_r, ps3_r;
  lstp_pkg::tag_t tg3_r;

  assign c2_rnd  = c2_r + 51'h8000_0000;
  assign pc2_rnd = pc2_r + 51'h8000_0000;

  always_ff @(posedge clk) begin
    if (en[13]) begin
      r3_r  <= r2_r;
      s3_r  <= c2_rnd[48:32];
      ps3_r <= pc2_rnd[48:32];
      tg3_r <= tg2_r;
    end
  end

  // Stage P4: scale by the configuration lengths.
  logic [16:0]    zf, xf;
  logic [18:0]    yf;
  logic [31:0]    zm4_r, xm4_r, gs4_r;
  logic [33:0]    ym4_r;
  lstp_pkg::tag_t tg4_r;

  always_comb begin
    unique case (tg3_r.phase)
      lstp_pkg::PH_LIFT: begin
        zf = s3_r;
        yf = 19'(r3_r);
        xf = s3_r;
      end
      lstp_pkg::PH_XFER: begin
        zf = lstp_pkg::ONE_Q16;
        yf = 19'(lstp_pkg::ONE_Q16) + 19'(s3_r) + 19'({s3_r, 1'b0});
        xf = s3_r;
      end
      default: begin
        zf = lstp_pkg::ONE_Q16 - s3_r;
        yf = lstp_pkg::FOUR_Q16 + 19'(s3_r);
        xf = lstp_pkg::ONE_Q16;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[14]) begin
      zm4_r <= 32'(clear_r) * 32'(zf);
      ym4_r <= 34'(step_len_r) * 34'(yf);
      xm4_r <= 32'(step_len_r) * 32'(xf);
      gs4_r <= 32'(gain_r) * 32'(ps3_r);
      tg4_r <= tg3_r;
    end
  end

  // Stage P5: z, stride word, signed products.
  logic [32:0]        zsum;
  logic [34:0]        ysum;
  logic signed [17:0] z5_r;
  logic [17:0]        w5_r;
  logic signed [48:0] xp5_r, dp5_r;
  lstp_pkg::tag_t     tg5_r;

  assign zsum = {1'b0, zm4_r} + 33'd32768;
  assign ysum = {1'b0, ym4_r} + lstp_pkg::HALF_5Q16;

  always_ff @(posedge clk) begin
    if (en[15]) begin
      z5_r  <= 18'(stand_r) - $signed({1'b0, zsum[32:16]});
      w5_r  <= ysum[33:16];
      xp5_r <= $signed({1'b0, xm4_r}) * tg4_r.vy;
      dp5_r <= $signed({1'b0, gs4_r}) * tg4_r.tr;
      tg5_r <= tg4_r;
    end
  end

  // Stage P6: divide the stride by five, round the 2^-28 products.
  function automatic logic signed [20:0] rnd28(logic signed [48:0] v);
    logic [48:0] mag;
    logic [48:0] sum;
    mag = v[48] ? 49'(-v) : 49'(v);
    sum = mag + 49'h800_0000;
    return v[48] ? -$signed({1'b0, sum[47:28]}) : $signed({1'b0, sum[47:28]});
  endfunction

  logic [33:0]        yq_prod;
  logic [15:0]        yq6_r;
  logic signed [20:0] xr6_r, d6_r;
  logic signed [17:0] z6_r;
  lstp_pkg::tag_t     tg6_r;

  assign yq_prod = 34'(w5_r) * 34'(lstp_pkg::DIV5_MUL);

  always_ff @(posedge clk) begin
    if (en[16]) begin
      yq6_r <= yq_prod[lstp_pkg::DIV5_SH+15:lstp_pkg::DIV5_SH];
      xr6_r <= rnd28(xp5_r);
      d6_r  <= rnd28(dp5_r);
      z6_r  <= z5_r;
      tg6_r <= tg5_r;
    end
  end

  // Stage P7: sums and saturation into the output register.
  function automatic logic [15:0] sat16(logic signed [22:0] v);
    if (v > 23'sd32767) begin
      return 16'h7FFF;
    end
    if (v < -23'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  logic signed [22:0] x_side, x_turn, x_sum, y_sum;
  logic [47:0]        out_tdata_r;

  always_comb begin
    x_side = 23'sd0;
    x_turn = 23'sd0;
    if (tg6_r.side && (tg6_r.phase != lstp_pkg::PH_LIFT)) begin
      x_side = 23'(xr6_r);
    end
    if (tg6_r.turn && (tg6_r.leg <= 3'd2)) begin
      x_turn = 23'(d6_r);
    end else if (tg6_r.turn && (tg6_r.leg >= 3'd5)) begin
      x_turn = -23'(d6_r);
    end
    x_sum = 23'(tg6_r.bx) + x_side + x_turn;
    y_sum = 23'(tg6_r.by);
    if (tg6_r.fwd) begin
      y_sum = tg6_r.neg ? y_sum + $signed({7'b0, yq6_r}) : y_sum - $signed({7'b0, yq6_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en[17]) begin
      out_tdata_r <= {sat16(23'(z6_r)), sat16(y_sum), sat16(x_sum)};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

### hdl/lstp_chk.sv
`include "leg_swing_trajectory_point_top_macros.svh"

module lstp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A result word that is not taken stays put.
  `LSTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // With the output free, the pipeline can always take a word.
  `LSTP_ASSERT_SAME(a_in_ready, clk, rst_n, !out_tvalid || out_tready, in_tready)

  // Register writes are never held off.
  `LSTP_ASSERT_SAME(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind leg_swing_trajectory_point_top lstp_chk u_lstp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

### tb/sv/lstp_checker.sv
`timescale 1ns / 100ps

module lstp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          points_seen
);
  import lstp_pkg::*;

  localparam longint NPTS = SWING_POINTS_DEF;
  localparam longint Q1 = 65536;

  longint stride_len, lift_h, ground_z, turn_gain, f_lift, f_xfer, f_lower;
  logic [47:0] target_q[$];

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint frac_q16(longint num, longint den);
    longint q;
    if (den == 0) return Q1;
    q = (num * Q1) / den;
    return (q > Q1) ? Q1 : q;
  endfunction

  function automatic longint ease_q16(longint x);
    logic [63:0] t;
    t = 64'(x) * 64'(x) * 64'(3 * Q1 - 2 * x);
    return longint'((t + 64'h8000_0000) >> 32);
  endfunction

  function automatic longint rdiv(longint a, longint d);
    return (a + d / 2) / d;
  endfunction

  function automatic longint rshift_away(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v < 0) return -((-v + half) >>> sh);
    return (v + half) >>> sh;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [47:0] foot_target(logic [95:0] w);
    longint stp, leg, bx, by, vx, vy, tr, sgn, t, a, b, r, s, x, y, z, d;
    logic fwd, side;
    stp = longint'(w[5:0]); leg = longint'(w[8:6]);
    bx = sx16(w[24:9]); by = sx16(w[40:25]); vx = sx16(w[56:41]);
    vy = sx16(w[72:57]); tr = sx16(w[88:73]);
    fwd = (vx > 40) || (vx < -40);
    side = (vy > 40) || (vy < -40);
    sgn = (vx > 0) ? 1 : -1;
    t = stp * Q1; a = f_lift * NPTS; b = (f_lift + f_xfer) * NPTS;
    x = bx; y = by;
    if (t <= a) begin
      r = frac_q16(t, a); s = ease_q16(r);
      z = ground_z - rdiv(lift_h * s, Q1);
      if (fwd) y = by - sgn * rdiv(stride_len * r, 5 * Q1);
    end else if (t <= b) begin
      r = frac_q16(t - a, f_xfer * NPTS); s = ease_q16(r);
      z = ground_z - lift_h;
      if (fwd) y = by - sgn * rdiv(stride_len * (Q1 + 3 * s), 5 * Q1);
      if (side) x = bx + rshift_away(stride_len * s * vy, 28);
    end else begin
      r = frac_q16(t - b, f_lower * NPTS); s = ease_q16(r);
      z = ground_z - rdiv(lift_h * (Q1 - s), Q1);
      if (fwd) y = by - sgn * rdiv(stride_len * (4 * Q1 + s), 5 * Q1);
      if (side) x = bx + rshift_away(stride_len * vy, 12);
    end
    if (tr > 40 || tr < -40) begin
      d = rshift_away(turn_gain * tr * ease_q16(frac_q16(stp, NPTS)), 28);
      if (leg <= 2) x += d;
      else if (leg >= 5) x -= d;
    end
    return {clip16(z), clip16(y), clip16(x)};
  endfunction

  assign pending = target_q.size();

  always @(posedge clk) begin
    logic [47:0] want;
    if (!rst_n) begin
      stride_len <= 1024; lift_h <= 768; ground_z <= -6144; turn_gain <= 256;
      f_lift <= 19661; f_xfer <= 26214; f_lower <= 19661;
      target_q.delete();
      fail_count <= 0;
      points_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_STEP_LENGTH: stride_len <= longint'(cfg_data[14:0]);
          REG_CLEARANCE:   lift_h <= longint'(cfg_data[14:0]);
          REG_STAND_H:     ground_z <= sx16(cfg_data);
          REG_TURN_GAIN:   turn_gain <= longint'(cfg_data[14:0]);
          REG_LIFT_FRAC:   f_lift <= longint'(cfg_data);
          REG_XFER_FRAC:   f_xfer <= longint'(cfg_data);
          REG_LOWER_FRAC:  f_lower <= longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) target_q.push_back(foot_target(in_tdata));
      if (out_tvalid && out_tready) begin
        points_seen <= points_seen + 1;
        if (target_q.size() == 0) begin
          $error("result word with no expectation: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = target_q.pop_front();
          if (want[15:0] !== out_tdata[15:0])
            $error("foot_x expected %0d actual %0d", $signed(want[15:0]),
                   $signed(out_tdata[15:0]));
          if (want[31:16] !== out_tdata[31:16])
            $error("foot_y expected %0d actual %0d", $signed(want[31:16]),
                   $signed(out_tdata[31:16]));
          if (want[47:32] !== out_tdata[47:32])
            $error("foot_z expected %0d actual %0d", $signed(want[47:32]),
                   $signed(out_tdata[47:32]));
          if (want !== out_tdata) fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule

### tb/sv/leg_swing_trajectory_point_top_tb.sv
`timescale 1ns / 100ps

module leg_swing_trajectory_point_top_tb;
  import lstp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending, points_seen;
  int          cycle_count = 0;
  logic        calm = 1'b0;
  int          words_sent = 0;

  leg_swing_trajectory_point_top u_dut (.*);
  lstp_checker u_chk (.*);

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver stalls at random except during the calm stretch.
  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 7);

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_addr <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic send_point(logic [5:0] stp, logic [2:0] leg, logic [15:0] bx,
                            logic [15:0] by, logic [15:0] vx, logic [15:0] vy,
                            logic [15:0] tr);
    while (!calm && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {7'd0, tr, vy, vx, by, bx, leg, stp};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_vel();
    case ($urandom_range(5))
      0: return 16'($urandom_range(81) - 41);
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_points(int count);
    repeat (count) begin
      send_point(6'($urandom_range(63)), 3'($urandom), 16'($urandom),
                 16'($urandom), pick_vel(), pick_vel(), pick_vel());
    end
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: extremes, deadband edges, beyond-swing index, odd leg ids.
    send_point(6'd0, 3'd1, 16'h0000, 16'h0000, 16'd41, 16'd41, 16'd41);
    send_point(6'd10, 3'd2, 16'h7fff, 16'h8000, 16'd40, -16'sd41, 16'd40);
    send_point(6'd25, 3'd3, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
    send_point(6'd40, 3'd4, 16'h1234, 16'h4321, 16'h7fff, 16'h8000, 16'h8000);
    send_point(6'd50, 3'd5, 16'h7fff, 16'h7fff, -16'sd40, 16'h7fff, 16'h7fff);
    send_point(6'd63, 3'd6, 16'h8000, 16'h8000, 16'h0000, 16'h8000, 16'h8000);
    send_point(6'd49, 3'd0, 16'h0100, 16'h0200, 16'h1000, 16'h1000, 16'h1000);
    send_point(6'd30, 3'd7, 16'hff00, 16'h0100, 16'hf000, 16'hf000, 16'h1000);
    in_tvalid <= 1'b0;
    wait_drained();
    // Extreme settings, including zero fractions.
    write_reg(REG_STEP_LENGTH, 16'h7fff); write_reg(REG_CLEARANCE, 16'h7fff);
    write_reg(REG_STAND_H, 16'h8000);     write_reg(REG_TURN_GAIN, 16'h7fff);
    write_reg(REG_LIFT_FRAC, 16'd0);      write_reg(REG_XFER_FRAC, 16'd0);
    write_reg(REG_LOWER_FRAC, 16'd0);
    random_points(150);
    wait_drained();
    write_reg(REG_STEP_LENGTH, 16'd0);    write_reg(REG_CLEARANCE, 16'd0);
    write_reg(REG_STAND_H, 16'h7fff);     write_reg(REG_TURN_GAIN, 16'd0);
    write_reg(REG_LIFT_FRAC, 16'hffff);   write_reg(REG_XFER_FRAC, 16'hffff);
    write_reg(REG_LOWER_FRAC, 16'hffff);
    random_points(150);
    wait_drained();
    repeat (4) begin
      write_reg(REG_STEP_LENGTH, 16'($urandom)); write_reg(REG_CLEARANCE, 16'($urandom));
      write_reg(REG_STAND_H, 16'($urandom));     write_reg(REG_TURN_GAIN, 16'($urandom));
      write_reg(REG_LIFT_FRAC, 16'($urandom_range(30000, 1)));
      write_reg(REG_XFER_FRAC, 16'($urandom_range(40000, 1)));
      write_reg(REG_LOWER_FRAC, 16'($urandom_range(30000, 1)));
      random_points(150);
      wait_drained();
    end
    // Back to defaults, then a long stretch with no stalls on either side.
    write_reg(REG_STEP_LENGTH, 16'd1024); write_reg(REG_CLEARANCE, 16'd768);
    write_reg(REG_STAND_H, 16'he800);     write_reg(REG_TURN_GAIN, 16'd256);
    write_reg(REG_LIFT_FRAC, 16'd19661);  write_reg(REG_XFER_FRAC, 16'd26214);
    write_reg(REG_LOWER_FRAC, 16'd19661);
    random_points(150);
    calm <= 1'b1;
    random_points(150);
    calm <= 1'b0;
    wait_drained();
    $display("Sent %0d input words and checked %0d foot targets over seven settings.",
             words_sent, points_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
